/* rtl/core/bmm_pkg.sv */
// shared types and constants of the banked memory map decoder
`timescale 1ns / 1ps

package bmm_pkg;

  localparam int unsigned RamAw   = 16;
  localparam int unsigned OsAw    = 14;
  localparam int unsigned BasicAw = 13;

  localparam logic [15:0] BankPortAddr = 16'd54017;

  localparam logic [15:0] IoLo       = 16'hD000;
  localparam logic [15:0] IoHi       = 16'hD800;
  localparam logic [15:0] OsLo       = 16'hC000;
  localparam logic [15:0] BasicLo    = 16'hA000;
  localparam logic [15:0] SelfLo     = 16'h5000;
  localparam logic [15:0] SelfHi     = 16'h5800;
  localparam logic [15:0] SelfOsBase = 16'h1000;

  localparam int unsigned PortOsBit    = 0;
  localparam int unsigned PortBasicBit = 1;
  localparam int unsigned PortSelfBit  = 7;

  typedef enum logic [2:0] {
    KIND_READ       = 3'd0,
    KIND_WRITE      = 3'd1,
    KIND_DIR_READ   = 3'd2,
    KIND_DIR_WRITE  = 3'd3,
    KIND_LOAD_OS    = 3'd4,
    KIND_LOAD_BASIC = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    SRC_ZERO  = 2'd0,
    SRC_RAM   = 2'd1,
    SRC_OS    = 2'd2,
    SRC_BASIC = 2'd3
  } src_e;

  // memory commands of one item
  typedef struct packed {
    logic                ram_re;
    logic                ram_we;
    logic                os_re;
    logic                os_we;
    logic                basic_re;
    logic                basic_we;
    logic [RamAw-1:0]    ram_addr;
    logic [OsAw-1:0]     os_addr;
    logic [BasicAw-1:0]  basic_addr;
    logic [7:0]          wdata;
    src_e                rd_src;
    logic                to_io;
    logic                drop;
  } ctrl_t;

endpackage

/* rtl/core/bmm_decode.sv */
// address decode: turns an item and the bank port byte into memory commands
`timescale 1ns / 1ps

module bmm_decode import bmm_pkg::*; (
  input  logic [2:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  port_i,
  output ctrl_t       ctrl_o
);

  logic        in_io, in_os, in_basic, in_self;
  logic        os_on, basic_on, self_on;
  logic        hit_os, hit_basic, hit_self;
  logic [15:0] os_off, basic_off, self_off;

  assign in_io    = (address_i >= IoLo) && (address_i < IoHi);
  assign in_os    = ((address_i >= OsLo) && (address_i < IoLo)) || (address_i >= IoHi);
  assign in_basic = (address_i >= BasicLo) && (address_i < OsLo);
  assign in_self  = (address_i >= SelfLo) && (address_i < SelfHi);

  assign os_on    = port_i[PortOsBit];
  assign basic_on = !port_i[PortBasicBit];
  assign self_on  = os_on && !port_i[PortSelfBit];

  assign hit_os    = in_os && os_on;
  assign hit_basic = in_basic && basic_on;
  assign hit_self  = in_self && self_on;

  assign os_off    = address_i - OsLo;
  assign basic_off = address_i - BasicLo;
  assign self_off  = address_i - SelfLo + SelfOsBase;

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.ram_addr   = address_i;
    ctrl_o.wdata      = write_data_i;
    ctrl_o.rd_src     = SRC_ZERO;
    ctrl_o.os_addr    = os_off[OsAw-1:0];
    ctrl_o.basic_addr = basic_off[BasicAw-1:0];
    unique case (kind_e'(kind_i))
      KIND_READ: begin
        if (in_io) begin
          ctrl_o.to_io = 1'b1;
        end else if (hit_os) begin
          ctrl_o.os_re  = 1'b1;
          ctrl_o.rd_src = SRC_OS;
        end else if (hit_basic) begin
          ctrl_o.basic_re = 1'b1;
          ctrl_o.rd_src   = SRC_BASIC;
        end else if (hit_self) begin
          ctrl_o.os_re   = 1'b1;
          ctrl_o.os_addr = self_off[OsAw-1:0];
          ctrl_o.rd_src  = SRC_OS;
        end else begin
          ctrl_o.ram_re = 1'b1;
          ctrl_o.rd_src = SRC_RAM;
        end
      end
      KIND_WRITE: begin
        if (in_io) begin
          ctrl_o.to_io = 1'b1;
        end else if (hit_os || hit_basic || hit_self) begin
          ctrl_o.drop = 1'b1;
        end else begin
          ctrl_o.ram_we = 1'b1;
        end
      end
      KIND_DIR_READ: begin
        ctrl_o.ram_re = 1'b1;
        ctrl_o.rd_src = SRC_RAM;
      end
      KIND_DIR_WRITE: begin
        ctrl_o.ram_we = 1'b1;
      end
      KIND_LOAD_OS: begin
        ctrl_o.os_addr = address_i[OsAw-1:0];
        ctrl_o.os_we   = (address_i[15:OsAw] == '0);
      end
      KIND_LOAD_BASIC: begin
        ctrl_o.basic_addr = address_i[BasicAw-1:0];
        ctrl_o.basic_we   = (address_i[15:BasicAw] == '0);
      end
      default: begin
        ctrl_o.rd_src = SRC_ZERO;
      end
    endcase
  end

endmodule

/* rtl/core/bmm_mem.sv */
// ram and rom arrays, ram clearing sweep after reset and bank port shadow
`timescale 1ns / 1ps

module bmm_mem import bmm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  ctrl_t      ctrl_i,
  output logic       clearing_o,
  output logic [7:0] port_o,
  output logic [7:0] ram_rdata_o,
  output logic [7:0] os_rdata_o,
  output logic [7:0] basic_rdata_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_e;

  logic [7:0] ram_q   [2**RamAw];
  logic [7:0] os_q    [2**OsAw];
  logic [7:0] basic_q [2**BasicAw];

  state_e           state_q, state_d;
  logic [RamAw-1:0] clr_q, clr_d;
  logic [7:0]       port_q, port_d;
  logic [7:0]       ram_rd_q, os_rd_q, basic_rd_q;

  logic             ram_we;
  logic [RamAw-1:0] ram_waddr;
  logic [7:0]       ram_wdata;

  assign clearing_o = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        clr_d = clr_q;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // the sweep owns the ram write port until it is done
  assign ram_we    = clearing_o || (en_i && ctrl_i.ram_we);
  assign ram_waddr = clearing_o ? clr_q : ctrl_i.ram_addr;
  assign ram_wdata = clearing_o ? 8'h00 : ctrl_i.wdata;

  // shadow of the ram byte at the bank port address
  assign port_d = (!clearing_o && ram_we && (ram_waddr == BankPortAddr))
                  ? ram_wdata : port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      port_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      port_q  <= port_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_q[ram_waddr] <= ram_wdata;
    end
    if (en_i && ctrl_i.ram_re) begin
      ram_rd_q <= ram_q[ctrl_i.ram_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.os_we) begin
      os_q[ctrl_i.os_addr] <= ctrl_i.wdata;
    end
    if (en_i && ctrl_i.os_re) begin
      os_rd_q <= os_q[ctrl_i.os_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctrl_i.basic_we) begin
      basic_q[ctrl_i.basic_addr] <= ctrl_i.wdata;
    end
    if (en_i && ctrl_i.basic_re) begin
      basic_rd_q <= basic_q[ctrl_i.basic_addr];
    end
  end

  assign port_o        = port_q;
  assign ram_rdata_o   = ram_rd_q;
  assign os_rdata_o    = os_rd_q;
  assign basic_rdata_o = basic_rd_q;

endmodule

/* rtl/core/banked_memory_map_decoder_top.sv */
// top level of the banked memory map decoder
//
//  channel  | ports                                         | timing
//  ---------+-----------------------------------------------+---------------------------
//  command  | start, busy, kind_i, address_i, write_data_i  | taken when start & !busy
//  result   | done_o, read_data_o, to_io_o, write_dropped_o | one cycle, done_o high
//
// an item is taken every cycle while busy is low; its result shows in the
// next cycle, as the memory read is synchronous
// after reset busy stays high while the ram is cleared
// writes land at the accepting edge, so the next item already reads them
// the receiver cannot stall: each result is valid for exactly one cycle
`timescale 1ns / 1ps

module banked_memory_map_decoder_top import bmm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [15:0] address_i,
  input  logic [7:0]  write_data_i,
  output logic        done_o,
  output logic [7:0]  read_data_o,
  output logic        to_io_o,
  output logic        write_dropped_o
);

  ctrl_t      ctrl;
  logic       accept;
  logic       clearing;
  logic [7:0] port;
  logic [7:0] ram_rdata, os_rdata, basic_rdata;

  logic valid_q, valid_d;
  src_e src_q, src_d;
  logic io_q, io_d;
  logic drop_q, drop_d;

  assign busy   = clearing;
  assign accept = start && !clearing;

  bmm_decode u_decode (
    .kind_i       (kind_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .port_i       (port),
    .ctrl_o       (ctrl)
  );

  bmm_mem u_mem (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (accept),
    .ctrl_i        (ctrl),
    .clearing_o    (clearing),
    .port_o        (port),
    .ram_rdata_o   (ram_rdata),
    .os_rdata_o    (os_rdata),
    .basic_rdata_o (basic_rdata)
  );

  assign valid_d = accept;
  assign src_d   = accept ? ctrl.rd_src : src_q;
  assign io_d    = accept ? ctrl.to_io : io_q;
  assign drop_d  = accept ? ctrl.drop : drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      src_q   <= SRC_ZERO;
      io_q    <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      src_q   <= src_d;
      io_q    <= io_d;
      drop_q  <= drop_d;
    end
  end

  always_comb begin
    case (src_q)
      SRC_RAM:   read_data_o = ram_rdata;
      SRC_OS:    read_data_o = os_rdata;
      SRC_BASIC: read_data_o = basic_rdata;
      default:   read_data_o = 8'h00;
    endcase
  end

  assign done_o          = valid_q;
  assign to_io_o         = io_q;
  assign write_dropped_o = drop_q;

endmodule
